// ===== rtl/sks_pkg.sv =====
package sks_pkg;

  localparam int KEY_W   = 32;
  localparam int REQ_W   = 2;
  localparam int COUNT_W = 11;

  // The largest positive key is reserved and is never stored
  localparam logic signed [KEY_W-1:0] SENTINEL_KEY = 32'sh7FFF_FFFF;

  // Request codes
  localparam logic [REQ_W-1:0] OP_ADD      = 2'd0;
  localparam logic [REQ_W-1:0] OP_REMOVE   = 2'd1;
  localparam logic [REQ_W-1:0] OP_CONTAINS = 2'd2;
  localparam logic [REQ_W-1:0] OP_CLEAR    = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_SRCH,
    ST_SRCH_CMP,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_INS_WR,
    ST_FINISH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;     // load the request, open the search window
    logic srch_rd;    // read the middle entry of the window
    logic srch_cmp;   // narrow the window with the read key
    logic ins_init;   // shift pointer to the top for an insert
    logic rem_init;   // shift pointer to the hit for a remove
    logic shift_rd;   // read the neighbor of the shift pointer
    logic shift_wr;   // write it at the shift pointer, step the pointer
    logic ins_wr;     // write the new key at its sorted place
    logic finish;     // load the result register, update the count
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [REQ_W-1:0] op;
    logic             is_sentinel;
    logic             srch_done;
    logic             hit;
    logic             full;
    logic             ins_done;
    logic             rem_done;
    logic             out_busy;
  } stat_t;

endpackage

// ===== rtl/sorted_key_set.sv =====
// Sorted key set: holds up to CAPACITY distinct signed 32-bit keys in ascending
// order in one RAM (one write and one registered read per cycle) and serves
// add, remove, contains and clear, one request at a time, each with exactly one
// result (success, full_reject, entry_count after the request; entry_count
// wraps to 11 bits above 2047 keys). Key 0x7FFFFFFF is reserved: add, remove and
// contains with it answer success 0. Clear and the reserved key go from the
// start state straight to the finish state; any other request first runs a
// binary search (one RAM read and one compare per halving, at most
// ceil(log2(count+1)) steps). An add that inserts then moves each entry above
// its sorted place up (read then write through the single RAM port) and
// writes the new key there; a remove that hits moves each entry above the hit
// down one place, closing the gap. A finished request waits while the
// previous result is still untaken. A new request is taken in the cycle after
// the previous one has reached the result register; the result waits there
// until taken. The RAM needs no clearing after reset: only entries below the
// count are ever read.
module sorted_key_set #(
  parameter int CAPACITY = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [sks_pkg::REQ_W-1:0]         req_type,
  input  logic signed [sks_pkg::KEY_W-1:0]  key,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              success,
  output logic                              full_reject,
  output logic [sks_pkg::COUNT_W-1:0]       entry_count
);
  import sks_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  sks_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sks_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .req_type    (req_type),
    .key         (key),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .success     (success),
    .full_reject (full_reject),
    .entry_count (entry_count)
  );

endmodule

// ===== rtl/sks_ram.sv =====
module sks_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/sks_ctrl.sv =====
module sks_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  sks_pkg::stat_t stat,
  output sks_pkg::cmd_t  cmd
);
  import sks_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_START;
        end
      end
      ST_START: begin
        if (stat.op == OP_CLEAR || stat.is_sentinel) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_SRCH;
        end
      end
      ST_SRCH: begin
        if (!stat.srch_done) begin
          cmd.srch_rd = 1'b1;
          state_next  = ST_SRCH_CMP;
        end else begin
          // Window closed: lower bound known, decide what to do with it
          case (stat.op)
            OP_ADD: begin
              if (stat.hit || stat.full) begin
                state_next = ST_FINISH;
              end else begin
                cmd.ins_init = 1'b1;
                state_next   = ST_SHIFT_RD;
              end
            end
            OP_REMOVE: begin
              if (stat.hit) begin
                cmd.rem_init = 1'b1;
                state_next   = ST_SHIFT_RD;
              end else begin
                state_next = ST_FINISH;
              end
            end
            default: begin
              state_next = ST_FINISH;
            end
          endcase
        end
      end
      ST_SRCH_CMP: begin
        cmd.srch_cmp = 1'b1;
        state_next   = ST_SRCH;
      end
      ST_SHIFT_RD: begin
        if (stat.op == OP_ADD) begin
          if (stat.ins_done) begin
            state_next = ST_INS_WR;
          end else begin
            cmd.shift_rd = 1'b1;
            state_next   = ST_SHIFT_WR;
          end
        end else begin
          if (stat.rem_done) begin
            state_next = ST_FINISH;
          end else begin
            cmd.shift_rd = 1'b1;
            state_next   = ST_SHIFT_WR;
          end
        end
      end
      ST_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        state_next   = ST_SHIFT_RD;
      end
      ST_INS_WR: begin
        cmd.ins_wr = 1'b1;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!stat.out_busy) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/sks_dpath.sv =====
module sks_dpath #(
  parameter int CAPACITY = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [sks_pkg::REQ_W-1:0]           req_type,
  input  logic signed [sks_pkg::KEY_W-1:0]    key,
  input  sks_pkg::cmd_t                       cmd,
  output sks_pkg::stat_t                      stat,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                success,
  output logic                                full_reject,
  output logic [sks_pkg::COUNT_W-1:0]         entry_count
);
  import sks_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  // Control state
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  // Request and walk registers
  logic [REQ_W-1:0]        op_q;
  logic signed [KEY_W-1:0] key_q;
  logic [CW-1:0]           lo;
  logic [CW-1:0]           hi;
  logic [CW-1:0]           idx;
  logic                    hit;

  // Memory port
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [KEY_W-1:0]  ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [KEY_W-1:0]  ram_rdata;

  logic [CW:0]   lo_hi_sum;
  logic [CW-1:0] mid;
  logic [CW-1:0] idx_dec;
  logic [CW:0]   idx_inc;
  logic          is_full;
  logic          res_success;
  logic          res_full;
  logic [COUNT_W+CW-1:0] count_ext;

  sks_ram #(
    .WIDTH (KEY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Search window midpoint and shift pointer neighbors
  assign lo_hi_sum = {1'b0, lo} + {1'b0, hi};
  assign mid       = lo_hi_sum[CW:1];
  assign idx_dec   = idx - 1'b1;
  assign idx_inc   = {1'b0, idx} + 1'b1;
  assign is_full   = (count == CW'(CAPACITY));

  // Memory addressing: insert moves entries up, remove moves them down
  assign ram_re    = cmd.srch_rd | cmd.shift_rd;
  assign ram_raddr = cmd.srch_rd ? mid[AW-1:0] :
                     (op_q == OP_ADD) ? idx_dec[AW-1:0] : idx_inc[AW-1:0];
  assign ram_we    = cmd.shift_wr | cmd.ins_wr;
  assign ram_waddr = cmd.ins_wr ? lo[AW-1:0] : idx[AW-1:0];
  assign ram_wdata = cmd.ins_wr ? key_q : ram_rdata;

  // Status to the controller
  always_comb begin
    stat             = '0;
    stat.op          = op_q;
    stat.is_sentinel = (key_q == SENTINEL_KEY);
    stat.srch_done   = (lo == hi);
    stat.hit         = hit;
    stat.full        = is_full;
    stat.ins_done    = (idx == lo);
    stat.rem_done    = (idx_inc >= {1'b0, count});
    stat.out_busy    = out_valid & ~out_ready;
  end

  // Result of the finished transaction
  always_comb begin
    res_success = 1'b0;
    res_full    = 1'b0;
    count_next  = count;
    case (op_q)
      OP_CLEAR: begin
        res_success = 1'b1;
        count_next  = '0;
      end
      OP_ADD: begin
        if (!stat.is_sentinel && !hit) begin
          if (is_full) begin
            res_full = 1'b1;
          end else begin
            res_success = 1'b1;
            count_next  = count + 1'b1;
          end
        end
      end
      OP_REMOVE: begin
        if (!stat.is_sentinel && hit) begin
          res_success = 1'b1;
          count_next  = count - 1'b1;
        end
      end
      default: begin
        res_success = ~stat.is_sentinel & hit;
      end
    endcase
  end

  assign count_ext = {{COUNT_W{1'b0}}, count_next};

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.finish) begin
        out_valid <= 1'b1;
        count     <= count_next;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Walk and payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q  <= req_type;
      key_q <= key;
      lo    <= '0;
      hi    <= count;
      hit   <= 1'b0;
    end
    // Lower-bound binary search; keys are distinct so an equal key is the bound
    if (cmd.srch_cmp) begin
      if ($signed(ram_rdata) < key_q) begin
        lo <= mid + 1'b1;
      end else begin
        hi <= mid;
      end
      if ($signed(ram_rdata) == key_q) begin
        hit <= 1'b1;
      end
    end
    if (cmd.ins_init) begin
      idx <= count;
    end
    if (cmd.rem_init) begin
      idx <= lo;
    end
    if (cmd.shift_wr) begin
      idx <= (op_q == OP_ADD) ? idx_dec : idx_inc[CW-1:0];
    end
    if (cmd.finish) begin
      success     <= res_success;
      full_reject <= res_full;
      entry_count <= count_ext[COUNT_W-1:0];
    end
  end

endmodule
